// ----- sv/shut_pkg.sv -----
// Shared types and constants for the sorted handle/UUID table.
// No dependencies; imported by shut_cmp and sorted_handle_uuid_table_top.
package shut_pkg;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_LOOKUP128 = 2'd1;
  localparam logic [1:0] OP_LOOKUP16  = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;

  localparam logic [63:0] BASE_UUID_LOW  = 64'h8000_0080_5F9B_34FB;
  localparam logic [63:0] BASE_UUID_HIGH = 64'h0000_0000_0000_1000;

  typedef struct packed {
    logic [15:0] handle;
    logic [63:0] uuid_high;
    logic [63:0] uuid_low;
  } entry_t;

  typedef struct packed {
    logic uuid_eq;
    logic h_eq;
    logic h_gt;
  } cmp_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

endpackage

// ----- sv/shut_cmp.sv -----
// Compares one stored entry against the request key and handle.
// Depends on shut_pkg.
module shut_cmp (
  input  shut_pkg::entry_t ent,
  input  logic [15:0]      handle,
  input  logic [63:0]      key_lo,
  input  logic [63:0]      key_hi,
  output shut_pkg::cmp_t   res
);
  import shut_pkg::*;

  always_comb begin
    res.uuid_eq = (ent.uuid_low == key_lo) && (ent.uuid_high == key_hi);
    res.h_eq    = (ent.handle == handle);
    res.h_gt    = (ent.handle > handle);
  end

endmodule

// ----- sv/sorted_handle_uuid_table_top.sv -----
// Top level of the sorted handle/UUID table: entry memory, walk sequencer.
// Depends on shut_pkg and shut_cmp.
//
// One request per start beat while busy is low; exactly one result beat per
// request, shown for one cycle with done high, and the receiver cannot stall
// it. Entries live in a single memory with a registered read port, walked one
// entry per cycle. Clear and insert-into-full finish straight from idle. A
// lookup scans until the matching entry or the last entry; a duplicate insert
// ends at the entry whose handle matches. An insert that lands below the last
// entry scans to its sorted slot p, then moves the count-p entries above it up
// by one and writes the new entry; an insert past the last entry writes it at
// the end. The memory walk sets the rate; start may be raised in the cycle
// done is high.
module sorted_handle_uuid_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [15:0] handle,
  input  logic [63:0] uuid_low,
  input  logic [63:0] uuid_high,
  input  logic [15:0] short_uuid,
  output logic        done,
  output logic [1:0]  status,
  output logic        found,
  output logic [15:0] handle_out
);
  import shut_pkg::*;

  state_t        state;
  logic [1:0]    op_q;
  logic [15:0]   h_q;
  logic [63:0]   key_lo;
  logic [63:0]   key_hi;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;

  entry_t        mem [DEPTH];
  entry_t        q;
  logic          we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;
  entry_t        wd;
  cmp_t          cmp;

  logic [CW-1:0] ptr_m1;
  logic          last;
  logic          is_ins;

  assign busy   = (state != S_IDLE);
  assign ptr_m1 = ptr - 1'b1;
  assign last   = (CW'(rd_idx) == (count - 1'b1));
  assign is_ins = (op_q == OP_INSERT);

  shut_cmp u_cmp (
    .ent    (q),
    .handle (h_q),
    .key_lo (key_lo),
    .key_hi (key_hi),
    .res    (cmp)
  );

  always_comb begin
    we = 1'b0;
    wa = pos[AW-1:0];
    wd = '{handle: h_q, uuid_high: key_hi, uuid_low: key_lo};
    ra = ptr[AW-1:0];
    if (state == S_SHIFT) begin
      ra = ptr_m1[AW-1:0];
      if (rd_vld) begin
        we = 1'b1;
        wa = rd_idx + 1'b1;
        wd = q;
      end else if (ptr == pos) begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ptr        <= '0;
      pos        <= '0;
      rd_vld     <= 1'b0;
      rd_idx     <= '0;
      done       <= 1'b0;
      status     <= ST_OK;
      found      <= 1'b0;
      handle_out <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q       <= op;
            h_q        <= handle;
            status     <= ST_OK;
            found      <= 1'b0;
            handle_out <= '0;
            ptr        <= '0;
            rd_vld     <= 1'b0;
            if (op == OP_LOOKUP16) begin
              key_lo <= BASE_UUID_LOW;
              key_hi <= BASE_UUID_HIGH | {16'h0, short_uuid, 32'h0};
            end else begin
              key_lo <= uuid_low;
              key_hi <= uuid_high;
            end
            if (op == OP_CLEAR) begin
              count <= '0;
              done  <= 1'b1;
            end else if (op == OP_INSERT && count >= CW'(DEPTH)) begin
              status <= ST_FULL;
              done   <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (ptr < count) ptr <= ptr + 1'b1;
          rd_vld <= (ptr < count);
          rd_idx <= ptr[AW-1:0];
          if (rd_vld && !is_ins && cmp.uuid_eq) begin
            found      <= 1'b1;
            handle_out <= q.handle;
            done       <= 1'b1;
            rd_vld     <= 1'b0;
            state      <= S_IDLE;
          end else if (rd_vld && is_ins && cmp.h_eq) begin
            status <= ST_DUP;
            done   <= 1'b1;
            rd_vld <= 1'b0;
            state  <= S_IDLE;
          end else if (rd_vld && is_ins && cmp.h_gt) begin
            pos    <= CW'(rd_idx);
            ptr    <= count;
            rd_vld <= 1'b0;
            state  <= S_SHIFT;
          end else if ((rd_vld && last) || (!rd_vld && ptr == count)) begin
            rd_vld <= 1'b0;
            if (is_ins) begin
              pos   <= count;
              ptr   <= count;
              state <= S_SHIFT;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          rd_vld <= (ptr > pos);
          rd_idx <= ptr_m1[AW-1:0];
          if (ptr > pos) ptr <= ptr_m1;
          if (!rd_vld && ptr == pos) begin
            count  <= count + 1'b1;
            done   <= 1'b1;
            rd_vld <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state  <= S_IDLE;
          rd_vld <= 1'b0;
        end
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("full reported below capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK && op_q == OP_INSERT) |-> (count == $past(count) + 1'b1))
    else $error("successful insert did not add one entry");

  a_found_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (op_q == OP_LOOKUP128 || op_q == OP_LOOKUP16))
    else $error("found set for a non-lookup request");

endmodule
